FILE: src/assert_macros.svh
// Assertion macros shared by the packet CRC-32 checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PCRC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define PCRC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: src/pcrc_pkg.sv
// Types, constants and the CRC table function of the packet CRC-32 checker.
`timescale 1ns / 1ps

package pcrc_pkg;

   localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
   localparam logic [31:0] CRC_XMASK = 32'hFF000000;

   localparam int          COUNT_W   = 17;
   localparam logic [16:0] COUNT_MAX = 17'h1FFFF;

   localparam int HDR_W = 7;
   localparam int OFS_W = 6;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 7;

   localparam logic [CSR_INDEX_W-1:0] REG_HEADER_SIZE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LENGTH_OFFSET   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_CHECKSUM_OFFSET = 2'd2;

   localparam logic [HDR_W-1:0] HEADER_SIZE_RESET     = 7'd16;
   localparam logic [OFS_W-1:0] LENGTH_OFFSET_RESET   = 6'd4;
   localparam logic [OFS_W-1:0] CHECKSUM_OFFSET_RESET = 6'd8;

   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_LENGTH   = 2'd1;
   localparam logic [1:0] ERR_CHECKSUM = 2'd2;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified byte on its way from the front part to the CRC engine.
   typedef struct packed {
      logic [7:0]  fed_byte;
      logic        last_byte;
      logic        length_error;
      logic [31:0] checksum;
   } pcrc_entry_type;

   function automatic logic [31:0] crc_entry(input logic [7:0] idx);
      logic [31:0] v;
      v = {24'd0, idx};
      for (int k = 0; k < 8; k++) begin
         v = (v[0] ? 32'd0 : CRC_POLY) ^ (v >> 1);
      end
      return v ^ CRC_XMASK;
   endfunction

endpackage

FILE: src/pcrc_req_if.sv
// Byte input channel of the packet CRC-32 checker.
`timescale 1ns / 1ps

interface pcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: src/pcrc_rsp_if.sv
// Verdict output channel of the packet CRC-32 checker.
`timescale 1ns / 1ps

interface pcrc_rsp_if;
   logic        valid;
   logic        ready;
   logic        packet_ok;
   logic [1:0]  error_code;
   logic [31:0] computed_crc;
   logic [31:0] received_checksum;

   modport source (output valid, output packet_ok, output error_code,
                   output computed_crc, output received_checksum, input ready);
   modport sink (input valid, input packet_ok, input error_code,
                 input computed_crc, input received_checksum, output ready);
endinterface

FILE: src/packet_crc32_checker.sv
// Top level of the packet CRC-32 checker.
`timescale 1ns / 1ps

// The checker takes one packet byte per cycle while its queue has room and, on the byte
// marked last, returns one verdict: a length mismatch is reported ahead of a checksum
// mismatch, and the CRC-32 computed with the checksum field read as zero is returned in
// every case. A byte passes from the front part through a four-entry queue into the CRC
// engine, whose table step is combinational; the last byte waits in the queue until the
// output register is free, its verdict is then registered there, and the next packet may
// follow at once. Registers should be written only while no packet is in flight.
module packet_crc32_checker
   import pcrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   pcrc_req_if.sink               req_if,
   pcrc_rsp_if.source             rsp_if
);

   logic           push_valid;
   logic           push_ready;
   pcrc_entry_type push_entry;
   logic           pop_valid;
   logic           pop_ready;
   pcrc_entry_type pop_entry;

   pcrc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req_if),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_entry       (push_entry)
   );

   pcrc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   pcrc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp_if    (rsp_if)
   );

endmodule

FILE: src/pcrc_front.sv
// Front part: configuration registers, byte counting, field capture and length check.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrc_front
   import pcrc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   pcrc_req_if.sink               req_if,
   output logic                   push_valid,
   input  logic                   push_ready,
   output pcrc_entry_type         push_entry
);

   logic [HDR_W-1:0]   header_size_ff;
   logic [OFS_W-1:0]   length_offset_ff;
   logic [OFS_W-1:0]   checksum_offset_ff;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [15:0]        length_ff, length_in;
   logic [31:0]        checksum_ff, checksum_in;
   logic [COUNT_W-1:0] length_pos;
   logic [COUNT_W-1:0] checksum_pos;
   logic               in_length;
   logic               in_checksum;
   logic [15:0]        diff;
   logic               accept;

   assign accept        = req_if.valid && push_ready;
   assign req_if.ready  = push_ready;
   assign push_valid    = req_if.valid;

   always_comb begin
      length_pos   = count_ff - {{(COUNT_W-OFS_W){1'b0}}, length_offset_ff};
      checksum_pos = count_ff - {{(COUNT_W-OFS_W){1'b0}}, checksum_offset_ff};
      in_length    = (count_ff >= {{(COUNT_W-OFS_W){1'b0}}, length_offset_ff}) &&
                     (length_pos < 17'd2);
      in_checksum  = (count_ff >= {{(COUNT_W-OFS_W){1'b0}}, checksum_offset_ff}) &&
                     (checksum_pos < 17'd4);

      length_in = length_ff;
      if (in_length) begin
         if (length_pos[0]) begin
            length_in = {req_if.data_byte, length_ff[7:0]};
         end else begin
            length_in = {length_ff[15:8], req_if.data_byte};
         end
      end

      checksum_in = checksum_ff;
      if (in_checksum) begin
         unique case (checksum_pos[1:0])
            2'd0: checksum_in = {checksum_ff[31:8], req_if.data_byte};
            2'd1: checksum_in = {checksum_ff[31:16], req_if.data_byte, checksum_ff[7:0]};
            2'd2: checksum_in = {checksum_ff[31:24], req_if.data_byte, checksum_ff[15:0]};
            default: checksum_in = {req_if.data_byte, checksum_ff[23:0]};
         endcase
      end

      count_in = (count_ff == COUNT_MAX) ? count_ff : count_ff + 17'd1;
      diff     = count_in[15:0] - {{(16-HDR_W){1'b0}}, header_size_ff};

      push_entry.fed_byte     = in_checksum ? 8'd0 : req_if.data_byte;
      push_entry.last_byte    = req_if.last_byte;
      push_entry.length_error = (diff != length_in);
      push_entry.checksum     = checksum_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_size_ff     <= HEADER_SIZE_RESET;
         length_offset_ff   <= LENGTH_OFFSET_RESET;
         checksum_offset_ff <= CHECKSUM_OFFSET_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_HEADER_SIZE:     header_size_ff     <= csr_write_data[HDR_W-1:0];
            REG_LENGTH_OFFSET:   length_offset_ff   <= csr_write_data[OFS_W-1:0];
            REG_CHECKSUM_OFFSET: checksum_offset_ff <= csr_write_data[OFS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         length_ff   <= '0;
         checksum_ff <= '0;
      end else if (accept) begin
         if (req_if.last_byte) begin
            count_ff    <= '0;
            length_ff   <= '0;
            checksum_ff <= '0;
         end else begin
            count_ff    <= count_in;
            length_ff   <= length_in;
            checksum_ff <= checksum_in;
         end
      end
   end

   `PCRC_ASSERT_NXT(a_front_clear_after_last, clock, reset, accept && req_if.last_byte, count_ff == '0 && length_ff == '0)

endmodule

FILE: src/pcrc_queue.sv
// Short queue of classified bytes between the front part and the CRC engine.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrc_queue
   import pcrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  pcrc_entry_type in_entry,
   output logic           out_valid,
   input  logic           out_ready,
   output pcrc_entry_type out_entry
);

   localparam logic [QCNT_W-1:0] QUEUE_FULL = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] PTR_LAST   = QPTR_W'(QUEUE_DEPTH - 1);

   pcrc_entry_type     slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               push;
   logic               pop;

   assign in_ready  = (count_ff != QUEUE_FULL);
   assign out_valid = (count_ff != '0);
   assign out_entry = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_entry;
      end
   end

   `PCRC_ASSERT_IMP(a_queue_bound, clock, reset, 1'b1, count_ff <= QUEUE_FULL)
   `PCRC_ASSERT_NXT(a_queue_drain, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1)

endmodule

FILE: src/pcrc_back.sv
// Back part: byte-wise CRC-32 engine, verdict and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcrc_back
   import pcrc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           pop_valid,
   output logic           pop_ready,
   input  pcrc_entry_type pop_entry,
   pcrc_rsp_if.source     rsp_if
);

   logic [31:0] crc_ff, crc_in;
   logic        out_valid_ff;
   logic        packet_ok_ff;
   logic [1:0]  error_ff, error_in;
   logic [31:0] computed_ff;
   logic [31:0] received_ff;
   logic        pop;
   logic        slot_free;

   assign slot_free = !out_valid_ff || rsp_if.ready;
   assign pop_ready = !pop_entry.last_byte || slot_free;
   assign pop       = pop_valid && pop_ready;

   always_comb begin
      crc_in = crc_entry(crc_ff[7:0] ^ pop_entry.fed_byte) ^ {8'd0, crc_ff[31:8]};
      priority if (pop_entry.length_error) begin
         error_in = ERR_LENGTH;
      end else if (pop_entry.checksum != crc_in) begin
         error_in = ERR_CHECKSUM;
      end else begin
         error_in = ERR_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            crc_ff <= pop_entry.last_byte ? 32'd0 : crc_in;
         end
         if (pop && pop_entry.last_byte) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && pop_entry.last_byte) begin
         packet_ok_ff <= (error_in == ERR_NONE);
         error_ff     <= error_in;
         computed_ff  <= crc_in;
         received_ff  <= pop_entry.checksum;
      end
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.packet_ok         = packet_ok_ff;
   assign rsp_if.error_code        = error_ff;
   assign rsp_if.computed_crc      = computed_ff;
   assign rsp_if.received_checksum = received_ff;

   `PCRC_ASSERT_NXT(a_back_crc_restart, clock, reset, pop && pop_entry.last_byte, crc_ff == 32'd0 && out_valid_ff)
   `PCRC_ASSERT_IMP(a_back_ok_matches_code, clock, reset, out_valid_ff, packet_ok_ff == (error_ff == ERR_NONE))

endmodule

FILE: dv/packet_crc32_checker_test.sv
// Self-checking testbench that predicts and compares every verdict of the packet CRC-32 checker.
`timescale 1ns / 1ps

module packet_crc32_checker_test;
   import pcrc_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] REG_UNMAPPED = 2'd3;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 12;
   localparam int HOLD_CYCLES   = 300;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int RANDOM_ITEMS  = 1800;

   typedef struct packed {
      logic        packet_ok;
      logic [1:0]  error_code;
      logic [31:0] computed_crc;
      logic [31:0] received_checksum;
   } verdict_type;

   typedef enum int {SINK_STEADY, SINK_COIN, SINK_SPARSE} sink_mode_type;

   class verdict_scoreboard;
      logic [HDR_W-1:0]   header_size;
      logic [OFS_W-1:0]   length_offset;
      logic [OFS_W-1:0]   checksum_offset;
      logic [31:0]        crc_acc;
      logic [COUNT_W-1:0] byte_count;
      logic [15:0]        length_field;
      logic [31:0]        checksum_field;
      verdict_type        expected_verdicts[$];
      int                 mismatches;

      function new();
         header_size = HEADER_SIZE_RESET;
         length_offset = LENGTH_OFFSET_RESET;
         checksum_offset = CHECKSUM_OFFSET_RESET;
         mismatches = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         crc_acc = 32'd0;
         byte_count = '0;
         length_field = 16'd0;
         checksum_field = 32'd0;
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction

      // One table step of the reflected CRC with inverted feedback.
      function logic [31:0] fold_byte(logic [31:0] crc, logic [7:0] b);
         logic [31:0] t;
         t = {24'd0, crc[7:0] ^ b};
         repeat (8) t = t[0] ? (t >> 1) : ((t >> 1) ^ CRC_POLY);
         return t ^ CRC_XMASK ^ (crc >> 8);
      endfunction

      function void note_byte(logic [7:0] b, logic last);
         int                 pos;
         int                 lo;
         int                 co;
         logic [7:0]         fed;
         logic [COUNT_W-1:0] diff;
         verdict_type        v;
         pos = int'(byte_count);
         lo = int'(length_offset);
         co = int'(checksum_offset);
         fed = b;
         if (pos >= lo && pos < lo + 2) length_field[(pos - lo) * 8 +: 8] = b;
         if (pos >= co && pos < co + 4) begin
            checksum_field[(pos - co) * 8 +: 8] = b;
            fed = 8'd0;
         end
         crc_acc = fold_byte(crc_acc, fed);
         if (byte_count != COUNT_MAX) byte_count = byte_count + 1'b1;
         if (last) begin
            diff = byte_count - {10'd0, header_size};
            v.computed_crc = crc_acc;
            v.received_checksum = checksum_field;
            if (diff[15:0] != length_field) begin
               v.error_code = ERR_LENGTH;
            end else if (checksum_field != crc_acc) begin
               v.error_code = ERR_CHECKSUM;
            end else begin
               v.error_code = ERR_NONE;
            end
            v.packet_ok = (v.error_code == ERR_NONE);
            expected_verdicts.push_back(v);
            clear_packet();
         end
      endfunction

      task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
         mismatches++;
         $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
      endtask

      task check_verdict(verdict_type got);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            report_mismatch("verdict with none expected", got.computed_crc, 32'd0);
         end else begin
            want = expected_verdicts.pop_front();
            if (got.packet_ok !== want.packet_ok)
               report_mismatch("packet_ok", 32'(got.packet_ok), 32'(want.packet_ok));
            if (got.error_code !== want.error_code)
               report_mismatch("error_code", 32'(got.error_code), 32'(want.error_code));
            if (got.computed_crc !== want.computed_crc)
               report_mismatch("computed_crc", got.computed_crc, want.computed_crc);
            if (got.received_checksum !== want.received_checksum)
               report_mismatch("received_checksum", got.received_checksum,
                               want.received_checksum);
         end
      endtask
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   pcrc_req_if req_bus();
   pcrc_rsp_if rsp_bus();

   verdict_scoreboard sb;
   logic [7:0]        packet_bytes[$];
   int                items_sent;
   int                burst_left;
   bit                gaps_enabled;
   bit                hold_request;
   int                cur_lofs;
   int                cur_cofs;
   int                cur_hdr;

   packet_crc32_checker u_top (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic send_byte(logic [7:0] b, logic last);
      int gap;
      req_bus.valid <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_byte(b, last);
      items_sent++;
      if (gaps_enabled) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 4);
            req_bus.valid <= 1'b0;
            req_bus.data_byte <= 8'($urandom);
            req_bus.last_byte <= 1'($urandom);
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_packet();
      int i;
      for (i = 0; i < packet_bytes.size(); i++) begin
         send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
      end
   endtask

   // The length field goes in first; with seal set, the CRC over the packet with its checksum
   // window read as zero is placed into that window, so overlapping fields come out broken.
   task automatic build_packet(int total, logic [15:0] len_value, logic seal);
      logic [31:0] crc;
      int          i;
      packet_bytes.delete();
      for (i = 0; i < total; i++) packet_bytes.push_back(8'($urandom));
      for (i = 0; i < 2; i++) begin
         if (cur_lofs + i < total) packet_bytes[cur_lofs + i] = len_value[i * 8 +: 8];
      end
      if (seal) begin
         crc = 32'd0;
         for (i = 0; i < total; i++) begin
            crc = sb.fold_byte(crc, (i >= cur_cofs && i < cur_cofs + 4) ? 8'd0
                                                                        : packet_bytes[i]);
         end
         for (i = 0; i < 4; i++) begin
            if (cur_cofs + i < total) packet_bytes[cur_cofs + i] = crc[i * 8 +: 8];
         end
      end
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_layout(int hdr, int lofs, int cofs);
      csr_write_enable <= 1'b1;
      csr_index <= REG_HEADER_SIZE;
      csr_write_data <= 7'(hdr);
      @(posedge clock);
      csr_index <= REG_LENGTH_OFFSET;
      csr_write_data <= {1'($urandom), 6'(lofs)};
      @(posedge clock);
      csr_index <= REG_CHECKSUM_OFFSET;
      csr_write_data <= {1'($urandom), 6'(cofs)};
      @(posedge clock);
      csr_index <= REG_UNMAPPED;
      csr_write_data <= 7'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cur_hdr = hdr & 127;
      cur_lofs = lofs & 63;
      cur_cofs = cofs & 63;
      sb.header_size = 7'(hdr);
      sb.length_offset = 6'(lofs);
      sb.checksum_offset = 6'(cofs);
   endtask

   task automatic random_packets(int budget);
      int start;
      int pick;
      int plen;
      int total;
      int idx;
      start = items_sent;
      while (items_sent - start < budget) begin
         pick = $urandom_range(0, 99);
         plen = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 300) : $urandom_range(0, 24);
         total = cur_hdr + plen;
         if (total == 0) total = 1;
         if (pick < 60) begin
            build_packet(total, 16'(plen), 1'b1);
         end else if (pick < 75) begin
            build_packet(total, 16'(plen), 1'b1);
            idx = $urandom_range(0, total - 1);
            packet_bytes[idx] = packet_bytes[idx] ^ (8'd1 << $urandom_range(0, 7));
         end else if (pick < 80) begin
            build_packet(total, 16'(plen) ^ (16'd1 << $urandom_range(0, 15)), 1'b1);
         end else if (pick < 85) begin
            build_packet(total, 16'(plen), 1'b1);
            if (packet_bytes.size() > 1 && $urandom_range(0, 1)) begin
               void'(packet_bytes.pop_back());
            end else begin
               packet_bytes.push_back(8'($urandom));
            end
         end else if (pick < 93) begin
            build_packet($urandom_range(1, (cur_hdr > 1) ? cur_hdr - 1 : 1), 16'(plen), 1'b1);
         end else begin
            build_packet($urandom_range(1, 40), 16'($urandom), 1'b0);
         end
         send_packet();
      end
   endtask

   task automatic random_phase(int hdr, int lofs, int cofs, int budget);
      program_layout(hdr, lofs, cofs);
      random_packets(budget);
      settle();
   endtask

   task automatic random_layout_phase();
      int hdr;
      int a;
      int lofs;
      int cofs;
      if ($urandom_range(0, 4) == 0) begin
         hdr = $urandom_range(0, 127);
         lofs = $urandom_range(0, 63);
         cofs = $urandom_range(0, 63);
      end else begin
         hdr = $urandom_range(6, 24);
         a = $urandom_range(0, hdr - 6);
         if ($urandom_range(0, 1)) begin
            lofs = a;
            cofs = $urandom_range(a + 2, hdr - 4);
         end else begin
            cofs = a;
            lofs = $urandom_range(a + 4, hdr - 2);
         end
      end
      random_phase(hdr, lofs, cofs, 200);
   endtask

   initial begin : result_sink
      sink_mode_type mode;
      int            mode_left;
      int            hold_left;
      verdict_type   got;
      mode = SINK_STEADY;
      mode_left = 0;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            got.packet_ok = rsp_bus.packet_ok;
            got.error_code = rsp_bus.error_code;
            got.computed_crc = rsp_bus.computed_crc;
            got.received_checksum = rsp_bus.received_checksum;
            sb.check_verdict(got);
         end
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            if (mode_left == 0) begin
               mode = sink_mode_type'($urandom_range(0, 2));
               mode_left = $urandom_range(4, 60);
            end
            mode_left--;
            case (mode)
               SINK_STEADY: rsp_bus.ready <= 1'b1;
               SINK_COIN: rsp_bus.ready <= 1'($urandom_range(0, 1));
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int i;
      sb = new();
      items_sent = 0;
      burst_left = 0;
      gaps_enabled = 1'b1;
      hold_request = 1'b0;
      cur_hdr = int'(HEADER_SIZE_RESET);
      cur_lofs = int'(LENGTH_OFFSET_RESET);
      cur_cofs = int'(CHECKSUM_OFFSET_RESET);
      reset <= 1'b1;
      csr_write_enable <= 1'b0;
      csr_index <= REG_HEADER_SIZE;
      csr_write_data <= '0;
      req_bus.valid <= 1'b0;
      req_bus.data_byte <= 8'd0;
      req_bus.last_byte <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // A header-only packet under the reset layout, then a corrupted payload and two
      // single-item packets at the extremes of the byte under a compact layout.
      build_packet(16, 16'd0, 1'b1);
      send_packet();
      settle();
      program_layout(6, 0, 2);
      build_packet(8, 16'd2, 1'b1);
      packet_bytes[7] = packet_bytes[7] ^ 8'h01;
      send_packet();
      packet_bytes = '{8'hFF};
      send_packet();
      packet_bytes = '{8'h00};
      send_packet();
      settle();

      // Tiny packets against a stalled receiver so that the internal queue fills up.
      hold_request = 1'b1;
      gaps_enabled = 1'b0;
      for (i = 0; i < 40; i++) begin
         build_packet($urandom_range(1, 3), 16'($urandom), 1'b0);
         send_packet();
      end
      gaps_enabled = 1'b1;
      settle();

      random_phase(1, 0, 0, 120);
      random_phase(64, 62, 60, 200);
      random_phase(127, 63, 63, 200);
      random_phase(0, 5, 1, 120);
      random_phase(16, 4, 8, 150);
      while (items_sent < RANDOM_ITEMS) random_layout_phase();

      req_bus.valid <= 1'b0;
      i = 0;
      while (sb.pending() != 0 && i < DRAIN_LIMIT) begin
         @(posedge clock);
         i++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.pending() != 0) begin
         sb.report_mismatch("verdicts never returned", 32'(sb.pending()), 32'd0);
      end
      if (sb.mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin : watchdog
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
